// ===== hdl/sbe_pkg.sv =====
package sbe_pkg;

    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int OP_W     = 4;
    localparam int PARAM_W  = 8;
    localparam int DEPTH_W  = 9;
    localparam int STATUS_W = 3;

    localparam int STACK_DEPTH_DEF   = 256;
    localparam int LOCAL_SLOTS_DEF   = 256;
    localparam int CONST_ENTRIES_DEF = 256;

    // Opcodes on the input channel
    localparam logic [OP_W-1:0] OP_CONST   = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd4;
    localparam logic [OP_W-1:0] OP_MOD     = 4'd5;
    localparam logic [OP_W-1:0] OP_HALT    = 4'd6;
    localparam logic [OP_W-1:0] OP_DROP    = 4'd7;
    localparam logic [OP_W-1:0] OP_STLOC   = 4'd8;
    localparam logic [OP_W-1:0] OP_LDLOC   = 4'd9;
    localparam logic [OP_W-1:0] OP_WCONST  = 4'd10;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZ    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EXIT    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_UNSET   = 3'd6;
    localparam logic [STATUS_W-1:0] STAT_HALTED  = 3'd7;

    typedef enum logic [3:0] {
        K_CONST, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
        K_EXIT, K_DISCARD, K_STORE, K_LOAD, K_WCONST, K_UNKNOWN
    } op_kind_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_kind_t            kind;
        logic [PARAM_W-1:0]  param;
        logic [DATA_W-1:0]   wval;
        logic                loc_in;
        logic                cst_in;
    } item_t;

    typedef enum logic [1:0] {
        S_IDLE, S_EXEC, S_MUL, S_DIV
    } state_t;

endpackage

// ===== hdl/sbe_ram.sv =====
module sbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sbe_div.sv =====
module sbe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sbe_pkg::DATA_W-1:0] dividend,
    input  logic [sbe_pkg::DATA_W-1:0] divisor,
    output logic [sbe_pkg::DATA_W-1:0] quotient,
    output logic [sbe_pkg::DATA_W-1:0] remainder,
    output logic                       done
);

    localparam int W  = sbe_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;

    // One restoring step per cycle, most significant bit first
    always_comb begin
        trial     = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
            end
            q_next   = {q_reg[W-2:0], ~trial[W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule

// ===== hdl/sbe_front.sv =====
module sbe_front #(
    parameter int LOCAL_SLOTS   = sbe_pkg::LOCAL_SLOTS_DEF,
    parameter int CONST_ENTRIES = sbe_pkg::CONST_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sbe_pkg::OP_W-1:0]    s_operation,
    input  logic [sbe_pkg::PARAM_W-1:0] s_param,
    input  logic [sbe_pkg::DATA_W-1:0]  s_write_value,
    output logic                        q_valid,
    output sbe_pkg::item_t              q_item,
    input  logic                        q_pop
);

    sbe_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    sbe_pkg::item_t cls;
    logic           push;
    logic           pop;

    // Classify the incoming opcode and range-check the parameter
    always_comb begin
        cls.param  = s_param;
        cls.wval   = s_write_value;
        cls.loc_in = (32'(s_param) < LOCAL_SLOTS);
        cls.cst_in = (32'(s_param) < CONST_ENTRIES);
        case (s_operation)
            sbe_pkg::OP_CONST:   cls.kind = sbe_pkg::K_CONST;
            sbe_pkg::OP_ADD:     cls.kind = sbe_pkg::K_ADD;
            sbe_pkg::OP_SUB:     cls.kind = sbe_pkg::K_SUB;
            sbe_pkg::OP_MUL:     cls.kind = sbe_pkg::K_MUL;
            sbe_pkg::OP_DIV:     cls.kind = sbe_pkg::K_DIV;
            sbe_pkg::OP_MOD:     cls.kind = sbe_pkg::K_MOD;
            sbe_pkg::OP_HALT:    cls.kind = sbe_pkg::K_EXIT;
            sbe_pkg::OP_DROP:    cls.kind = sbe_pkg::K_DISCARD;
            sbe_pkg::OP_STLOC:   cls.kind = sbe_pkg::K_STORE;
            sbe_pkg::OP_LDLOC:   cls.kind = sbe_pkg::K_LOAD;
            sbe_pkg::OP_WCONST:  cls.kind = sbe_pkg::K_WCONST;
            default:             cls.kind = sbe_pkg::K_UNKNOWN;
        endcase
    end

    // Two-entry queue toward the back end
    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hdl/sbe_back.sv =====
module sbe_back #(
    parameter int STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_SLOTS   = sbe_pkg::LOCAL_SLOTS_DEF,
    parameter int CONST_ENTRIES = sbe_pkg::CONST_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  sbe_pkg::item_t               q_item,
    output logic                         q_pop,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [sbe_pkg::DATA_W-1:0]   m_top_value,
    output logic [sbe_pkg::DEPTH_W-1:0]  m_depth,
    output logic [sbe_pkg::STATUS_W-1:0] m_status,
    output logic [sbe_pkg::DATA_W-1:0]   m_exit_value
);

    localparam int W   = sbe_pkg::DATA_W;
    localparam int H   = sbe_pkg::HALF_W;
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LD  = (LOCAL_SLOTS < 256) ? LOCAL_SLOTS : 256;
    localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
    localparam int CD  = (CONST_ENTRIES < 256) ? CONST_ENTRIES : 256;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;

    sbe_pkg::state_t state_reg, state_next;

    logic [DW-1:0]  depth_reg, depth_next;
    logic [W-1:0]   top_reg, top_next;
    logic           halted_reg, halted_next;
    logic [LD-1:0]  lvalid_reg, lvalid_next;

    sbe_pkg::item_t                cur_reg;
    logic [sbe_pkg::STATUS_W-1:0]  fault_reg;
    logic                          lok_reg;

    logic [1:0]     mstep_reg, mstep_next;
    logic [W-1:0]   opl_reg, opl_next;
    logic [W-1:0]   opr_reg, opr_next;
    logic [W-1:0]   prod_reg, prod_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic           qneg_reg, qneg_next;
    logic           rneg_reg, rneg_next;

    logic                          m_valid_reg, m_valid_next;
    logic [W-1:0]                  m_top_reg, m_top_next;
    logic [sbe_pkg::DEPTH_W-1:0]   m_depth_reg, m_depth_next;
    logic [sbe_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [W-1:0]                  m_exit_reg, m_exit_next;

    logic                          issue;
    logic                          full;
    logic [sbe_pkg::STATUS_W-1:0]  fault;
    logic [SAW-1:0]                stk_raddr, stk_waddr;
    logic                          stk_we;
    logic [W-1:0]                  stk_rdata;
    logic [LAW-1:0]                loc_addr;
    logic                          loc_we;
    logic [W-1:0]                  loc_rdata;
    logic [CAW-1:0]                cst_addr;
    logic                          cst_we;
    logic [W-1:0]                  cst_rdata;
    logic [H-1:0]                  mul_a, mul_b;
    logic [W-1:0]                  mul_p;
    logic                          div_start, div_done;
    logic [W-1:0]                  div_a, div_b, div_q, div_r;
    logic                          commit;
    logic [sbe_pkg::STATUS_W-1:0]  cm_status;
    logic [W-1:0]                  cm_exit;
    logic [W-1:0]                  res;

    function automatic logic [sbe_pkg::DATA_W-1:0] magnitude(
        input logic [sbe_pkg::DATA_W-1:0] v
    );
        return v[sbe_pkg::DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign full  = (depth_reg == DW'(STACK_DEPTH));
    assign issue = (state_reg == sbe_pkg::S_IDLE) && q_valid && (!m_valid_reg || m_ready);
    assign q_pop = issue;

    // Decide at issue whether the item faults and changes nothing
    always_comb begin
        fault = sbe_pkg::STAT_OK;
        if (halted_reg) begin
            fault = sbe_pkg::STAT_HALTED;
        end else begin
            case (q_item.kind)
                sbe_pkg::K_CONST, sbe_pkg::K_LOAD: begin
                    if (full) fault = sbe_pkg::STAT_OVER;
                end
                sbe_pkg::K_ADD, sbe_pkg::K_SUB, sbe_pkg::K_MUL: begin
                    if (depth_reg < DW'(2)) fault = sbe_pkg::STAT_UNDER;
                end
                sbe_pkg::K_DIV, sbe_pkg::K_MOD: begin
                    if (depth_reg < DW'(2)) fault = sbe_pkg::STAT_UNDER;
                    else if (top_reg == '0) fault = sbe_pkg::STAT_DIVZ;
                end
                sbe_pkg::K_EXIT, sbe_pkg::K_DISCARD, sbe_pkg::K_STORE: begin
                    if (depth_reg == '0) fault = sbe_pkg::STAT_UNDER;
                end
                sbe_pkg::K_WCONST: fault = sbe_pkg::STAT_OK;
                default: fault = sbe_pkg::STAT_UNKNOWN;
            endcase
        end
    end

    // Memory addressing: the top entry lives in top_reg, the rest in RAM
    assign stk_raddr = (depth_reg >= DW'(2)) ? SAW'(depth_reg - DW'(2)) : '0;
    assign stk_waddr = SAW'(depth_reg - DW'(1));
    assign loc_addr  = q_item.loc_in ? q_item.param[LAW-1:0] : '0;
    assign cst_addr  = q_item.cst_in ? q_item.param[CAW-1:0] : '0;
    assign loc_we    = issue && (fault == sbe_pkg::STAT_OK)
                       && (q_item.kind == sbe_pkg::K_STORE) && q_item.loc_in;
    assign cst_we    = issue && (fault == sbe_pkg::STAT_OK)
                       && (q_item.kind == sbe_pkg::K_WCONST) && q_item.cst_in;

    always_comb begin
        lvalid_next = lvalid_reg;
        if (loc_we) begin
            lvalid_next[loc_addr] = 1'b1;
        end
    end

    sbe_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (top_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbe_ram #(.WIDTH(W), .DEPTH(LD), .AW(LAW)) u_locals (
        .aclk  (aclk),
        .we    (loc_we),
        .waddr (loc_addr),
        .wdata (top_reg),
        .raddr (loc_addr),
        .rdata (loc_rdata)
    );

    sbe_ram #(.WIDTH(W), .DEPTH(CD), .AW(CAW)) u_consts (
        .aclk  (aclk),
        .we    (cst_we),
        .waddr (cst_addr),
        .wdata (q_item.wval),
        .raddr (cst_addr),
        .rdata (cst_rdata)
    );

    sbe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    assign div_a = magnitude(stk_rdata);
    assign div_b = magnitude(top_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbe_pkg::S_IDLE: begin
                if (issue) state_next = sbe_pkg::S_EXEC;
            end
            sbe_pkg::S_EXEC: begin
                state_next = sbe_pkg::S_IDLE;
                if (fault_reg == sbe_pkg::STAT_OK) begin
                    if (cur_reg.kind == sbe_pkg::K_MUL) begin
                        state_next = sbe_pkg::S_MUL;
                    end else if (cur_reg.kind == sbe_pkg::K_DIV
                                 || cur_reg.kind == sbe_pkg::K_MOD) begin
                        state_next = sbe_pkg::S_DIV;
                    end
                end
            end
            sbe_pkg::S_MUL: begin
                if (mstep_reg == 2'd3) state_next = sbe_pkg::S_IDLE;
            end
            sbe_pkg::S_DIV: begin
                if (div_done) state_next = sbe_pkg::S_IDLE;
            end
            default: state_next = sbe_pkg::S_IDLE;
        endcase
    end

    // One 32x32 partial product per multiply step
    always_comb begin
        case (mstep_reg)
            2'd0:    begin mul_a = opl_reg[H-1:0]; mul_b = opr_reg[H-1:0]; end
            2'd1:    begin mul_a = opl_reg[H-1:0]; mul_b = opr_reg[W-1:H]; end
            default: begin mul_a = opl_reg[W-1:H]; mul_b = opr_reg[H-1:0]; end
        endcase
        mul_p = W'(mul_a) * W'(mul_b);
    end

    // Datapath and result register
    always_comb begin
        top_next    = top_reg;
        depth_next  = depth_reg;
        halted_next = halted_reg;
        stk_we      = 1'b0;
        commit      = 1'b0;
        cm_status   = fault_reg;
        cm_exit     = '0;
        res         = '0;
        div_start   = 1'b0;
        mstep_next  = mstep_reg;
        opl_next    = opl_reg;
        opr_next    = opr_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        qneg_next   = qneg_reg;
        rneg_next   = rneg_reg;

        case (state_reg)
            sbe_pkg::S_EXEC: begin
                if (fault_reg != sbe_pkg::STAT_OK) begin
                    commit = 1'b1;
                end else begin
                    case (cur_reg.kind)
                        sbe_pkg::K_CONST: begin
                            commit     = 1'b1;
                            stk_we     = (depth_reg != '0);
                            top_next   = cur_reg.cst_in ? cst_rdata : '0;
                            depth_next = depth_reg + DW'(1);
                        end
                        sbe_pkg::K_LOAD: begin
                            commit     = 1'b1;
                            stk_we     = (depth_reg != '0);
                            top_next   = lok_reg ? loc_rdata : '0;
                            depth_next = depth_reg + DW'(1);
                            cm_status  = lok_reg ? sbe_pkg::STAT_OK : sbe_pkg::STAT_UNSET;
                        end
                        sbe_pkg::K_ADD: begin
                            commit     = 1'b1;
                            top_next   = stk_rdata + top_reg;
                            depth_next = depth_reg - DW'(1);
                        end
                        sbe_pkg::K_SUB: begin
                            commit     = 1'b1;
                            top_next   = stk_rdata - top_reg;
                            depth_next = depth_reg - DW'(1);
                        end
                        sbe_pkg::K_MUL: begin
                            opl_next   = stk_rdata;
                            opr_next   = top_reg;
                            mstep_next = 2'd0;
                        end
                        sbe_pkg::K_DIV, sbe_pkg::K_MOD: begin
                            div_start = 1'b1;
                            qneg_next = stk_rdata[W-1] ^ top_reg[W-1];
                            rneg_next = stk_rdata[W-1];
                        end
                        sbe_pkg::K_EXIT: begin
                            commit      = 1'b1;
                            cm_exit     = top_reg;
                            cm_status   = sbe_pkg::STAT_EXIT;
                            halted_next = 1'b1;
                            top_next    = stk_rdata;
                            depth_next  = depth_reg - DW'(1);
                        end
                        sbe_pkg::K_DISCARD, sbe_pkg::K_STORE: begin
                            commit     = 1'b1;
                            top_next   = stk_rdata;
                            depth_next = depth_reg - DW'(1);
                        end
                        default: begin
                            commit = 1'b1;
                        end
                    endcase
                end
            end
            sbe_pkg::S_MUL: begin
                prod_next  = mul_p;
                mstep_next = mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0: acc_next = '0;
                    2'd1: acc_next = prod_reg;
                    2'd2: acc_next = acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
                    default: begin
                        commit     = 1'b1;
                        top_next   = acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
                        depth_next = depth_reg - DW'(1);
                    end
                endcase
            end
            sbe_pkg::S_DIV: begin
                if (cur_reg.kind == sbe_pkg::K_DIV) begin
                    res = qneg_reg ? (~div_q + 1'b1) : div_q;
                end else begin
                    res = rneg_reg ? (~div_r + 1'b1) : div_r;
                end
                if (div_done) begin
                    commit     = 1'b1;
                    top_next   = res;
                    depth_next = depth_reg - DW'(1);
                end
            end
            default: begin
                mstep_next = mstep_reg;
            end
        endcase

        // Load the result register, or drain it when taken
        m_valid_next  = m_valid_reg && !m_ready;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        m_status_next = m_status_reg;
        m_exit_next   = m_exit_reg;
        if (commit) begin
            m_valid_next  = 1'b1;
            m_top_next    = (depth_next == '0) ? '0 : top_next;
            m_depth_next  = sbe_pkg::DEPTH_W'(depth_next);
            m_status_next = cm_status;
            m_exit_next   = cm_exit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbe_pkg::S_IDLE;
            depth_reg   <= '0;
            halted_reg  <= 1'b0;
            lvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
            mstep_reg   <= 2'd0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            halted_reg  <= halted_next;
            lvalid_reg  <= lvalid_next;
            m_valid_reg <= m_valid_next;
            mstep_reg   <= mstep_next;
        end
        top_reg      <= top_next;
        opl_reg      <= opl_next;
        opr_reg      <= opr_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        qneg_reg     <= qneg_next;
        rneg_reg     <= rneg_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
        m_status_reg <= m_status_next;
        m_exit_reg   <= m_exit_next;
        if (issue) begin
            cur_reg   <= q_item;
            fault_reg <= fault;
            lok_reg   <= q_item.loc_in && lvalid_reg[loc_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_top_value  = m_top_reg;
    assign m_depth      = m_depth_reg;
    assign m_status     = m_status_reg;
    assign m_exit_value = m_exit_reg;

endmodule

// ===== hdl/stack_bytecode_execute.sv =====
// Stack-machine instruction executor.
// Input channel (s_valid/s_ready): one instruction per item, with opcode,
// parameter and the value for a constant-table write. Result channel
// (m_valid/m_ready): one item per instruction with top of stack, depth,
// status and exit value, in instruction order.
// A two-entry queue classifies and holds incoming items; the executor
// pulls one at a time. Most instructions are issued with memory reads,
// then executed. Multiply runs four steps of a shared 32x32 multiplier.
// Divide and modulo run on the restoring divider, one bit per cycle.
// The result sits in an output register; the executor issues the next
// item only once that register is empty or being taken, so a stalled
// receiver holds the executor, and after the queue fills, s_ready drops.
// Reset clears the stack depth, the halted flag and all local valid bits;
// no clearing pass runs. After an exit instruction that does not fault,
// every later item reports the halted status until reset.
module stack_bytecode_execute #(
    parameter int STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_SLOTS   = sbe_pkg::LOCAL_SLOTS_DEF,
    parameter int CONST_ENTRIES = sbe_pkg::CONST_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sbe_pkg::OP_W-1:0]     s_operation,
    input  logic [sbe_pkg::PARAM_W-1:0]  s_param,
    input  logic [sbe_pkg::DATA_W-1:0]   s_write_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbe_pkg::DATA_W-1:0]   m_top_value,
    output logic [sbe_pkg::DEPTH_W-1:0]  m_depth,
    output logic [sbe_pkg::STATUS_W-1:0] m_status,
    output logic [sbe_pkg::DATA_W-1:0]   m_exit_value
);

    logic           q_valid;
    logic           q_pop;
    sbe_pkg::item_t q_item;

    // Accept and classify
    sbe_front #(
        .LOCAL_SLOTS   (LOCAL_SLOTS),
        .CONST_ENTRIES (CONST_ENTRIES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_param       (s_param),
        .s_write_value (s_write_value),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // Execute
    sbe_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .LOCAL_SLOTS   (LOCAL_SLOTS),
        .CONST_ENTRIES (CONST_ENTRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_top_value  (m_top_value),
        .m_depth      (m_depth),
        .m_status     (m_status),
        .m_exit_value (m_exit_value)
    );

`ifndef SYNTHESIS
    // An empty stack reports a zero top
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_depth == '0) |-> (m_top_value == '0))
        else $error("nonzero top on empty stack");

    // Exit value is only carried by an exit item
    a_exit_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != sbe_pkg::STAT_EXIT) |-> (m_exit_value == '0))
        else $error("exit value on non-exit item");

    // The item right after a delivered exit is halted
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_status == sbe_pkg::STAT_EXIT)
        |=> !m_valid || (m_status == sbe_pkg::STAT_HALTED))
        else $error("item executed after exit");
`endif

endmodule

// ===== tb/tb_stack_bytecode_execute.sv =====
`timescale 1ns / 1ps

module tb_stack_bytecode_execute;
    import sbe_pkg::*;

    localparam logic [OP_W-1:0] OP_BAD_LO = 4'd11;
    localparam logic [OP_W-1:0] OP_BAD_HI = 4'd15;
    localparam int NSTACK     = STACK_DEPTH_DEF;
    localparam int NLOCAL     = LOCAL_SLOTS_DEF;
    localparam int NCONST     = CONST_ENTRIES_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int LATE_ITEMS = 760;
    localparam int MIN_NEG_IDX = 255;
    localparam int MINUS1_IDX  = 1;
    localparam int ZERO_IDX    = 2;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [PARAM_W-1:0] prm;
        logic [DATA_W-1:0]  wval;
        bit                 drain;
    } instr_t;

    typedef struct {
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   exit_val;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = '0;
    logic [PARAM_W-1:0] s_param = '0;
    logic [DATA_W-1:0] s_write_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DATA_W-1:0] m_top_value;
    logic [DEPTH_W-1:0] m_depth;
    logic [STATUS_W-1:0] m_status;
    logic [DATA_W-1:0] m_exit_value;

    instr_t   pending_instrs[$];
    outcome_t expected_outcomes[$];
    int       n_issued = 0;
    int       n_total = 0;
    int       n_results = 0;
    int       n_mismatch = 0;
    bit       gen_done = 0;

    // Shadow machine state
    logic [DATA_W-1:0] shadow_stack[NSTACK];
    int                shadow_depth;
    logic [DATA_W-1:0] shadow_locals[NLOCAL];
    bit                shadow_local_set[NLOCAL];
    logic [DATA_W-1:0] shadow_consts[NCONST];
    bit                shadow_halted;

    stack_bytecode_execute dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_param(s_param),
        .s_write_value(s_write_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_top_value(m_top_value), .m_depth(m_depth),
        .m_status(m_status), .m_exit_value(m_exit_value)
    );

    always #5 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] abs64(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? -v : v;
    endfunction

    // Signed integer arithmetic wrapping at 64 bits; divide truncates toward zero
    function automatic logic [DATA_W-1:0] arith(logic [OP_W-1:0] op,
                                                logic [DATA_W-1:0] a,
                                                logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_DIV: begin
                q = abs64(a) / abs64(b);
                return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
            end
            default: begin
                q = abs64(a) % abs64(b);
                return a[DATA_W-1] ? -q : q;
            end
        endcase
    endfunction

    // Execute one instruction on the shadow state and return its outcome
    function automatic outcome_t execute_instr(instr_t it);
        outcome_t o;
        logic [DATA_W-1:0] a, b, v;
        bit ok;
        o.status = STAT_OK;
        o.exit_val = '0;
        if (shadow_halted) begin
            o.status = STAT_HALTED;
        end else begin
            case (it.op)
                OP_CONST, OP_LDLOC: begin
                    ok = 1;
                    if (it.op == OP_CONST) begin
                        v = shadow_consts[it.prm];
                    end else begin
                        ok = shadow_local_set[it.prm];
                        v = ok ? shadow_locals[it.prm] : '0;
                    end
                    if (shadow_depth >= NSTACK) begin
                        o.status = STAT_OVER;
                    end else begin
                        shadow_stack[shadow_depth] = v;
                        shadow_depth++;
                        if (!ok) o.status = STAT_UNSET;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                    if (shadow_depth < 2) begin
                        o.status = STAT_UNDER;
                    end else begin
                        b = shadow_stack[shadow_depth-1];
                        a = shadow_stack[shadow_depth-2];
                        if ((it.op == OP_DIV || it.op == OP_MOD) && b == '0) begin
                            o.status = STAT_DIVZ;
                        end else begin
                            shadow_depth--;
                            shadow_stack[shadow_depth-1] = arith(it.op, a, b);
                        end
                    end
                end
                OP_HALT, OP_DROP, OP_STLOC: begin
                    if (shadow_depth == 0) begin
                        o.status = STAT_UNDER;
                    end else begin
                        shadow_depth--;
                        if (it.op == OP_HALT) begin
                            o.exit_val = shadow_stack[shadow_depth];
                            o.status = STAT_EXIT;
                            shadow_halted = 1;
                        end else if (it.op == OP_STLOC) begin
                            shadow_locals[it.prm] = shadow_stack[shadow_depth];
                            shadow_local_set[it.prm] = 1;
                        end
                    end
                end
                OP_WCONST: shadow_consts[it.prm] = it.wval;
                default: o.status = STAT_UNKNOWN;
            endcase
        end
        o.top = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        o.depth = shadow_depth[DEPTH_W-1:0];
        return o;
    endfunction

    // Driver: present items from the pending queue, with random gaps
    int  gap_left = 0;
    bit  drain_wait = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(execute_instr('{s_operation, s_param,
                                                           s_write_value, 1'b0}));
                n_issued++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_instrs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_instrs[0].drain && expected_outcomes.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (n_issued < LATE_ITEMS && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    s_valid <= 1'b0;
                end else begin
                    s_operation   <= pending_instrs[0].op;
                    s_param       <= pending_instrs[0].prm;
                    s_write_value <= pending_instrs[0].wval;
                    void'(pending_instrs.pop_front());
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check results against the oldest expectation; stall at random
    int  stall_left = 0;
    bit  long_hold_done = 0;
    outcome_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_outcomes.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: top=%h depth=%0d status=%0d",
                                 m_top_value, m_depth, m_status);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_top_value !== want.top || m_depth !== want.depth ||
                        m_status !== want.status || m_exit_value !== want.exit_val) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"result %0d mismatch: exp top=%h depth=%0d st=%0d ",
                                      "exit=%h, got top=%h depth=%0d st=%0d exit=%h"},
                                     n_results, want.top, want.depth, want.status,
                                     want.exit_val, m_top_value, m_depth, m_status,
                                     m_exit_value);
                    end
                end
            end
            // Hold off once for a long stretch so the input backs up
            if (!long_hold_done && n_results == 300) begin
                long_hold_done = 1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (n_results < LATE_ITEMS && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus
    int  est_depth = 0;
    int  known_consts[$];

    task automatic queue_instr(logic [OP_W-1:0] op, logic [PARAM_W-1:0] prm,
                               logic [DATA_W-1:0] wv = '0, bit drain = 0);
        pending_instrs.push_back('{op, prm, wv, drain});
        n_total++;
        case (op)
            OP_CONST, OP_LDLOC:
                if (est_depth < NSTACK) est_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                if (est_depth >= 2) est_depth--;
            OP_HALT, OP_DROP, OP_STLOC:
                if (est_depth > 0) est_depth--;
            OP_WCONST: known_consts.push_back(int'(prm));
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return DATA_W'($signed($urandom_range(0, 20)) - 10);
            default: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] pick_const();
        return PARAM_W'(known_consts[$urandom_range(0, known_consts.size() - 1)]);
    endfunction

    function automatic logic [OP_W-1:0] pick_arith();
        logic [OP_W-1:0] ops[5] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD};
        return ops[$urandom_range(0, 4)];
    endfunction

    initial begin
        int k, n;
        logic [OP_W-1:0] rop;
        for (int i = 0; i < NLOCAL; i++) shadow_local_set[i] = 0;
        shadow_depth = 0;
        shadow_halted = 0;

        // Directed: extremes, every opcode, error cases
        queue_instr(OP_WCONST, 0, 64'h7fff_ffff_ffff_ffff);
        queue_instr(OP_WCONST, PARAM_W'(MIN_NEG_IDX), 64'h8000_0000_0000_0000);
        queue_instr(OP_WCONST, PARAM_W'(MINUS1_IDX), '1);
        queue_instr(OP_WCONST, PARAM_W'(ZERO_IDX), '0);
        queue_instr(OP_WCONST, 3, 64'd7);
        queue_instr(OP_HALT, 0);
        queue_instr(OP_ADD, 0);
        queue_instr(OP_CONST, 3);
        queue_instr(OP_CONST, PARAM_W'(ZERO_IDX));
        queue_instr(OP_DIV, 0);
        queue_instr(OP_MOD, 0);
        queue_instr(OP_DROP, 0);
        queue_instr(OP_CONST, PARAM_W'(MIN_NEG_IDX));
        queue_instr(OP_CONST, PARAM_W'(MINUS1_IDX));
        queue_instr(OP_DIV, 0);
        queue_instr(OP_CONST, PARAM_W'(MINUS1_IDX));
        queue_instr(OP_MOD, 0);
        queue_instr(OP_CONST, 0);
        queue_instr(OP_ADD, 0);
        queue_instr(OP_CONST, 3);
        queue_instr(OP_MUL, 0);
        queue_instr(OP_STLOC, 255);
        queue_instr(OP_LDLOC, 255);
        queue_instr(OP_LDLOC, 6);
        queue_instr(OP_SUB, 0);
        queue_instr(OP_DROP, 0);
        queue_instr(OP_DROP, 0);
        queue_instr(OP_STLOC, 0);
        queue_instr(OP_DROP, 0);
        queue_instr(OP_BAD_LO, 0);
        queue_instr(OP_BAD_HI, 8'hff, '1);

        // Random: mostly well-formed expressions over constants and locals
        k = 0;
        while (n_total < 830) begin
            k++;
            if (k == 40) begin
                // Fill to overflow, then fold it back down
                while (est_depth < NSTACK)
                    queue_instr($urandom_range(0, 3) == 0 ? OP_LDLOC : OP_CONST,
                                $urandom_range(0, 3) == 0 ? PARAM_W'($urandom)
                                                          : pick_const());
                queue_instr(OP_CONST, pick_const());
                queue_instr(OP_LDLOC, PARAM_W'($urandom));
                while (est_depth > 1)
                    queue_instr($urandom_range(0, 1) ? OP_ADD : OP_DROP, 0);
                queue_instr(OP_CONST, pick_const(), '0, 1);
                continue;
            end
            case ($urandom_range(0, 9))
                0, 1: queue_instr(OP_WCONST, PARAM_W'($urandom), rand_value());
                2: begin
                    // Any opcode, but no halt and no read of an unwritten constant
                    rop = OP_W'($urandom_range(0, 15));
                    if (rop == OP_CONST || rop == OP_HALT) rop = OP_LDLOC;
                    queue_instr(rop, PARAM_W'($urandom), {$urandom, $urandom});
                end
                3: begin
                    queue_instr(OP_CONST, pick_const());
                    queue_instr(OP_STLOC, PARAM_W'($urandom));
                    queue_instr(OP_LDLOC, $urandom_range(0, 1) ? PARAM_W'($urandom)
                                                               : 8'($urandom_range(0, 7)));
                end
                default: begin
                    n = $urandom_range(2, 4);
                    for (int j = 0; j < n; j++)
                        queue_instr(($urandom_range(0, 3) == 0) ? OP_LDLOC : OP_CONST,
                                    pick_const());
                    for (int j = 1; j < n; j++)
                        queue_instr(pick_arith(), 0);
                    if (est_depth > 6) queue_instr(OP_DROP, 0);
                end
            endcase
        end

        // Exit, then everything reports halted
        queue_instr(OP_CONST, pick_const(), '0, 1);
        queue_instr(OP_HALT, 0);
        queue_instr(OP_WCONST, 9, '1);
        queue_instr(OP_CONST, 0);
        queue_instr(OP_LDLOC, 3);
        queue_instr(OP_BAD_HI, 0);
        queue_instr(OP_ADD, 0);
        gen_done = 1;
    end

    // Reset, then wait for all items and results
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (gen_done && n_issued == n_total);
        wait (expected_outcomes.size() == 0);
        repeat (200) @(posedge aclk);
        if (n_mismatch == 0 && expected_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== stack_bytecode_execute.f =====
hdl/sbe_pkg.sv
hdl/sbe_ram.sv
hdl/sbe_div.sv
hdl/sbe_front.sv
hdl/sbe_back.sv
hdl/stack_bytecode_execute.sv
tb/tb_stack_bytecode_execute.sv
